// File: hw/rtl/slmc_pkg.sv
`default_nettype none
package slmc_pkg;

   localparam int SineTableDepthDefault = 256;
   localparam logic [16:0] WatchdogResetMs = 17'd60000;
   localparam logic [7:0] FramePeriodResetMs = 8'd17;
   localparam logic [13:0] BlendDurationResetMs = 14'd500;
   localparam logic [13:0] BlendDurationMaxMs = 14'd10000;
   localparam logic [15:0] StepModerate = 16'd364;
   localparam logic [15:0] StepSlow = 16'd218;
   localparam logic [23:0] VersionWord = 24'h000404;

   localparam logic [2:0] MODE_OFF = 3'd0;
   localparam logic [2:0] MODE_SOLID = 3'd1;
   localparam logic [2:0] MODE_BREATHE = 3'd2;
   localparam logic [2:0] MODE_SLOW = 3'd3;
   localparam logic [2:0] MODE_DISC = 3'd4;

   localparam logic [7:0] CMD_PING = 8'd1;
   localparam logic [7:0] CMD_OFF = 8'd2;
   localparam logic [7:0] CMD_SOLID = 8'd3;
   localparam logic [7:0] CMD_BREATHE = 8'd4;
   localparam logic [7:0] CMD_SLOW = 8'd5;
   localparam logic [7:0] CMD_BRIGHT = 8'd6;
   localparam logic [7:0] CMD_TRANS = 8'd7;
   localparam logic [7:0] CMD_RESTART = 8'd8;
   localparam logic [7:0] CMD_BOOT = 8'd9;
   localparam logic [7:0] CMD_VERSION = 8'd10;

   localparam logic [2:0] RSP_PONG = 3'd0;
   localparam logic [2:0] RSP_OK = 3'd1;
   localparam logic [2:0] RSP_ERROR = 3'd2;
   localparam logic [2:0] RSP_VERSION = 3'd3;
   localparam logic [2:0] RSP_RESTART = 3'd4;
   localparam logic [2:0] RSP_BOOT = 3'd5;

   localparam logic CSR_WATCHDOG = 1'b0;
   localparam logic CSR_FRAME = 1'b1;

   typedef struct packed {
      logic       action;
      logic [3:0] report_length;
      logic [7:0] command;
      logic [7:0] arg_one;
      logic [7:0] arg_two;
      logic [7:0] arg_three;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [2:0]  response_code;
      logic [23:0] version_word;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  brightness;
      logic        last;
   } rsp_type;

endpackage
`default_nettype wire

// File: hw/rtl/slmc_divider.sv
`default_nettype none
// Restoring divider: quotient of a 22-bit dividend by a 14-bit divisor, one
// quotient bit per cycle.
module slmc_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [21:0] dividend,
   input  wire logic [13:0] divisor,
   output logic             done,
   output logic [21:0]      quotient
);
   logic [21:0] quo_ff, quo_in;
   logic [14:0] rem_ff, rem_in;
   logic [13:0] div_ff, div_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [14:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {rem_ff[13:0], quo_ff[21]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quo_in = {quo_ff[20:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[20:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd21) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done = busy_ff && (cnt_ff == 5'd21);
   assign quotient = {quo_ff[20:0], (trial >= {1'b0, div_ff})};
endmodule
`default_nettype wire

// File: hw/rtl/slmc_mult.sv
`default_nettype none
// Shared 18 by 18 unsigned multiplier with a registered product.
module slmc_mult (
   input  wire logic        clock,
   input  wire logic [17:0] op_a,
   input  wire logic [17:0] op_b,
   output logic [35:0]      product
);
   logic [35:0] prod_ff, prod_in;
   assign prod_in = op_a * op_b;
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
   assign product = prod_ff;
endmodule
`default_nettype wire

// File: hw/rtl/status_led_mode_controller.sv
`default_nettype none
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  slmc_pkg::req_type
// rsp_      out        rsp_valid / rsp_stall  slmc_pkg::rsp_type
// csr_      in         csr_write_enable       index 0 watchdog, 1 frame period
//
// A host command is decoded in the idle state and its result transactions are then
// sent from the send state. A tick without a frame returns to idle, and a solid or
// off frame goes through the decide state. Breathe, slow and disconnected frames run
// the multiply program on the one shared multiplier, and a blend frame also runs
// the bit-serial divider and the mixing steps.
// Reset is synchronous and restores all mode state. A stalled result holds
// the block in its send state; no new transaction is taken until it leaves.
module status_led_mode_controller #(
   parameter int SINE_TABLE_DEPTH = slmc_pkg::SineTableDepthDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire slmc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output slmc_pkg::rsp_type     rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_index,
   input  wire logic [16:0]      csr_write_data
);
   import slmc_pkg::*;

   // The phase is quantized to the table depth by keeping its top bits.
   localparam int IdxBits = $clog2(SINE_TABLE_DEPTH);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_TICK = 4'd1;
   localparam logic [3:0] ST_MUL = 4'd2;  // run the multiply program
   localparam logic [3:0] ST_DIV = 4'd3;
   localparam logic [3:0] ST_MIX = 4'd4;
   localparam logic [3:0] ST_DECIDE = 4'd5;
   localparam logic [3:0] ST_SEND = 4'd6;

   logic [3:0]  state_ff, state_in;
   logic [16:0] wd_limit_ff, wd_limit_in;
   logic [7:0]  period_ff, period_in;
   logic [2:0]  mode_ff, mode_in;
   logic [23:0] target_ff, target_in, shown_ff, shown_in, start_ff, start_in;
   logic [16:0] quiet_ff, quiet_in;
   logic [7:0]  fms_ff, fms_in;
   logic [15:0] phase_ff, phase_in;
   logic        blending_ff, blending_in;
   logic [13:0] elapsed_ff, elapsed_in, dur_ff, dur_in;
   logic [7:0]  bright_ff, bright_in;
   rsp_type     out0_ff, out0_in, out1_ff, out1_in;
   logic        two_ff, two_in;
   logic        sel_ff, sel_in;
   logic [4:0]  step_ff, step_in;
   logic [17:0] acc_ff, acc_in;   // working value of the sine program and of the blend mix
   logic [17:0] x_ff, x_in, x2_ff, x2_in;
   logic        neg_ff, neg_in;
   logic [23:0] col_ff, col_in, next_ff, next_in, bcol_ff, bcol_in;
   logic [7:0]  p_ff, p_in;

   logic [17:0] ma, mb;
   logic [35:0] prod;
   logic        div_start, div_done;
   logic [21:0] div_q;

   slmc_mult u_mult (.clock(clock), .op_a(ma), .op_b(mb), .product(prod));
   slmc_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend({8'd0, elapsed_ff} * 22'd255), .divisor(dur_ff),
      .done(div_done), .quotient(div_q)
   );

   function automatic rsp_type mk_frame(input logic [23:0] c, input logic [7:0] b);
      rsp_type r;
      r = '0;
      r.kind = 1'b1;
      r.red = c[23:16];
      r.green = c[15:8];
      r.blue = c[7:0];
      r.brightness = b;
      return r;
   endfunction

   // Index of the first phase step after a watchdog trip, as a quadrant offset.
   function automatic logic [15:0] xq_zero_step();
      logic [IdxBits-1:0] i;
      logic [15:0] a;
      i = StepModerate[15 -: IdxBits];
      a = 16'({i, {(16 - IdxBits){1'b0}}});
      return {1'b0, a[13:0], 1'b0};
   endfunction

   logic [15:0] new_phase, ang;
   logic [IdxBits-1:0] pidx;
   logic [15:0] xq;
   logic [17:0] h;
   logic [7:0]  ca, cb;

   always_comb begin
      new_phase = phase_ff + ((mode_ff == MODE_SLOW) ? StepSlow : StepModerate);
      pidx = new_phase[15 -: IdxBits];
      ang = 16'({pidx, {(16 - IdxBits){1'b0}}});
      xq = {1'b0, ang[13:0], 1'b0};
      h = 18'((18'd32768 + (neg_ff ? -acc_ff : acc_ff)) >> 1);
      ca = start_ff[8*(2 - step_ff[2:1]) +: 8];
      cb = next_ff[8*(2 - step_ff[2:1]) +: 8];
   end

   // Multiplier operand selection for the sine program and the blend.
   always_comb begin
      ma = '0;
      mb = '0;
      if (state_ff == ST_MUL) begin
         case (step_ff)
            5'd0: begin ma = x_ff; mb = x_ff; end
            5'd2: begin ma = 18'd2320; mb = x2_ff; end
            5'd4: begin ma = 18'd21024 - acc_ff; mb = x2_ff; end
            5'd6: begin ma = 18'd51472 - acc_ff; mb = x_ff; end
            5'd8: begin ma = h; mb = h; end
            5'd10: begin ma = {10'd0, col_ff[23:16]}; mb = acc_ff; end
            5'd11: begin ma = {10'd0, col_ff[15:8]}; mb = acc_ff; end
            5'd12: begin ma = {10'd0, col_ff[7:0]}; mb = acc_ff; end
            default: ;
         endcase
      end else if (state_ff == ST_MIX) begin
         if (!step_ff[0]) begin
            ma = {10'd0, ca}; mb = 18'd256 - {10'd0, p_ff};
         end else begin
            ma = {10'd0, cb}; mb = {10'd0, p_ff} + 18'd1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      wd_limit_in = wd_limit_ff;
      period_in = period_ff;
      mode_in = mode_ff;
      target_in = target_ff;
      shown_in = shown_ff;
      start_in = start_ff;
      quiet_in = quiet_ff;
      fms_in = fms_ff;
      phase_in = phase_ff;
      blending_in = blending_ff;
      elapsed_in = elapsed_ff;
      dur_in = dur_ff;
      bright_in = bright_ff;
      out0_in = out0_ff;
      out1_in = out1_ff;
      two_in = two_ff;
      sel_in = sel_ff;
      step_in = step_ff;
      acc_in = acc_ff;
      x_in = x_ff;
      x2_in = x2_ff;
      neg_in = neg_ff;
      col_in = col_ff;
      next_in = next_ff;
      bcol_in = bcol_ff;
      p_in = p_ff;
      div_start = 1'b0;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WATCHDOG: wd_limit_in = csr_write_data;
            CSR_FRAME: period_in = csr_write_data[7:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.action) begin
                  if (quiet_ff != 17'h1FFFF) quiet_in = quiet_ff + 17'd1;
                  if (blending_ff && elapsed_ff != 14'h3FFF)
                     elapsed_in = elapsed_ff + 14'd1;
                  if (fms_ff != 8'hFF) fms_in = fms_ff + 8'd1;
                  state_in = ST_TICK;
               end else if (req_data.report_length >= 4'd4) begin
                  out0_in = '0;
                  out0_in.response_code = RSP_OK;
                  out0_in.last = 1'b1;
                  two_in = 1'b0;
                  sel_in = 1'b0;
                  state_in = ST_SEND;
                  if (req_data.command >= CMD_PING && req_data.command <= CMD_TRANS)
                     quiet_in = '0;
                  if (req_data.command >= CMD_OFF && req_data.command <= CMD_SLOW
                      && dur_ff != '0) begin
                     start_in = shown_ff;
                     elapsed_in = '0;
                     blending_in = 1'b1;
                  end
                  case (req_data.command)
                     CMD_PING: begin
                        out0_in.response_code = RSP_PONG;
                        if (mode_ff == MODE_DISC) begin
                           mode_in = MODE_OFF;
                           if (dur_ff != '0) begin
                              start_in = shown_ff;
                              elapsed_in = '0;
                              blending_in = 1'b1;
                           end
                        end
                     end
                     CMD_OFF: mode_in = MODE_OFF;
                     CMD_SOLID, CMD_BREATHE, CMD_SLOW: begin
                        target_in = {req_data.arg_one, req_data.arg_two,
                                     req_data.arg_three};
                        mode_in = (req_data.command == CMD_SOLID) ? MODE_SOLID :
                                  (req_data.command == CMD_BREATHE) ? MODE_BREATHE
                                                                    : MODE_SLOW;
                     end
                     CMD_BRIGHT: begin
                        bright_in = req_data.arg_one;
                        out1_in = out0_in;
                        out0_in = mk_frame(shown_ff, req_data.arg_one);
                        two_in = 1'b1;
                     end
                     CMD_TRANS: begin
                        dur_in = ({req_data.arg_one, req_data.arg_two} > 16'd10000) ?
                                 BlendDurationMaxMs :
                                 {req_data.arg_one[5:0], req_data.arg_two};
                     end
                     CMD_RESTART: out0_in.response_code = RSP_RESTART;
                     CMD_BOOT: out0_in.response_code = RSP_BOOT;
                     CMD_VERSION: begin
                        out0_in.response_code = RSP_VERSION;
                        out0_in.version_word = VersionWord;
                     end
                     default: out0_in.response_code = RSP_ERROR;
                  endcase
               end
            end
         end
         ST_TICK: begin
            state_in = ST_IDLE;
            if (mode_ff != MODE_DISC && quiet_ff > wd_limit_ff) begin
               mode_in = MODE_DISC;
               phase_in = '0;
            end else if (fms_ff >= period_ff) begin
               fms_in = '0;
               next_in = (mode_ff == MODE_SOLID) ? target_ff : '0;
               col_in = (mode_ff == MODE_DISC) ? 24'hFFFFFF : target_ff;
               if (mode_ff == MODE_BREATHE || mode_ff == MODE_SLOW
                   || mode_ff == MODE_DISC) begin
                  phase_in = new_phase;
                  x_in = {2'd0, ang[14] ? 16'd32768 - xq : xq};
                  neg_in = ang[15];
                  step_in = '0;
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_DECIDE;
               end
            end
            // Watchdog trip and frame check share the tick: re-enter for frame.
            if (mode_ff != MODE_DISC && quiet_ff > wd_limit_ff) begin
               if (fms_ff >= period_ff) begin
                  fms_in = '0;
                  col_in = 24'hFFFFFF;
                  x_in = {2'd0, xq_zero_step()};
                  neg_in = 1'b0;
                  phase_in = StepModerate;
                  step_in = '0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            step_in = step_ff + 5'd1;
            case (step_ff)
               5'd1: x2_in = prod[32:15];
               5'd3, 5'd5: acc_in = prod[32:15];
               5'd7: acc_in = prod[32:15];
               5'd9: acc_in = prod[32:15];
               5'd11: next_in[23:16] = prod[22:15];
               5'd12: next_in[15:8] = prod[22:15];
               5'd13: begin
                  next_in[7:0] = prod[22:15];
                  state_in = ST_DECIDE;
               end
               default: ;
            endcase
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
            if (blending_ff) begin
               if (elapsed_ff >= dur_ff) begin
                  blending_in = 1'b0;
                  shown_in = next_ff;
                  out0_in = mk_frame(next_ff, bright_ff);
                  out0_in.last = 1'b1;
                  two_in = 1'b0;
                  sel_in = 1'b0;
                  state_in = ST_SEND;
               end else begin
                  div_start = 1'b1;
                  state_in = ST_DIV;
               end
            end else if (next_ff != shown_ff) begin
               shown_in = next_ff;
               out0_in = mk_frame(next_ff, bright_ff);
               out0_in.last = 1'b1;
               two_in = 1'b0;
               sel_in = 1'b0;
               state_in = ST_SEND;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               p_in = div_q[7:0];
               step_in = '0;
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            // Even steps issue the start term, odd steps the target term;
            // products come from the registered multiplier at the next step and are summed in acc.
            step_in = step_ff + 5'd1;
            if (step_ff != 5'd0) begin
               if (step_ff[0]) acc_in = prod[17:0];
               else begin
                  bcol_in[8*(2 - (step_ff[2:1] - 2'd1)) +: 8] =
                     8'((acc_ff + prod[17:0]) >> 8);
               end
            end
            if (step_ff == 5'd6) begin
               shown_in = {bcol_ff[23:8], 8'((acc_ff + prod[17:0]) >> 8)};
               out0_in = mk_frame({bcol_ff[23:8], 8'((acc_ff + prod[17:0]) >> 8)},
                                  bright_ff);
               out0_in.last = 1'b1;
               two_in = 1'b0;
               sel_in = 1'b0;
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               if (two_ff && !sel_ff) sel_in = 1'b1;
               else state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wd_limit_ff <= WatchdogResetMs;
         period_ff <= FramePeriodResetMs;
         mode_ff <= MODE_OFF;
         target_ff <= '0;
         shown_ff <= '0;
         start_ff <= '0;
         quiet_ff <= '0;
         fms_ff <= '0;
         phase_ff <= '0;
         blending_ff <= 1'b0;
         elapsed_ff <= '0;
         dur_ff <= BlendDurationResetMs;
         bright_ff <= 8'hFF;
         two_ff <= 1'b0;
         sel_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         wd_limit_ff <= wd_limit_in;
         period_ff <= period_in;
         mode_ff <= mode_in;
         target_ff <= target_in;
         shown_ff <= shown_in;
         start_ff <= start_in;
         quiet_ff <= quiet_in;
         fms_ff <= fms_in;
         phase_ff <= phase_in;
         blending_ff <= blending_in;
         elapsed_ff <= elapsed_in;
         dur_ff <= dur_in;
         bright_ff <= bright_in;
         two_ff <= two_in;
         sel_ff <= sel_in;
         step_ff <= step_in;
      end
      out0_ff <= out0_in;
      out1_ff <= out1_in;
      acc_ff <= acc_in;
      x_ff <= x_in;
      x2_ff <= x2_in;
      neg_ff <= neg_in;
      col_ff <= col_in;
      next_ff <= next_in;
      bcol_ff <= bcol_in;
      p_ff <= p_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_SEND);
   assign rsp_data = sel_ff ? out1_ff : out0_ff;
endmodule
`default_nettype wire
